// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module of the block.
// Expects signals named clk and rst_n (synchronous, active low) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check cons in the same cycle as ante
`define LCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcwseq assertion failed");

// check cons in the cycle after ante
`define LCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcwseq assertion failed");

`endif

// ===== rtl/core/lcwseq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the banded display window sequencer.
// No dependencies; the RTL modules use it by scoped names, the bench imports it.
package lcwseq_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT    = 3'd0,
    REG_RECT_TOP     = 3'd1,
    REG_RECT_WIDTH   = 3'd2,
    REG_RECT_HEIGHT  = 3'd3,
    REG_BAND_ROWS    = 3'd4,
    REG_PANEL_OFFSET = 3'd5,
    REG_PIXEL_BASE   = 3'd6
  } cfg_reg_t;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_DESC   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [21:0] BYTES_MAX = 22'h3FFFFF;

  typedef struct packed {
    logic [9:0]  left;
    logic [9:0]  top;
    logic [10:0] width;
    logic [10:0] height;
    logic [10:0] band;
    logic [7:0]  offset;
    logic [31:0] base;
  } cfg_t;

  typedef struct packed {
    logic        is_band;
    logic        more;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [10:0] rows;
    logic [10:0] rows_base;
  } front_item_t;

  typedef struct packed {
    logic        is_band;
    logic        more;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [21:0] len_prod;
    logic [21:0] addr_prod;
  } q_entry_t;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_t;

endpackage

// ===== rtl/core/lcd_chunked_window_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the banded display window sequencer: configuration registers,
// front part, queue and back part. Uses lcwseq_pkg and the lcwseq_* modules.
//
// A start request (mode 0) arms the block, clears the row count and gives no
// result. A continue request gives either one status result or a band: eleven
// window bytes (CASET, RASET, RAMWR with parameters) and one transfer descriptor.
// The back sequencer issues one result per cycle while out_ready does not stall
// it. A request is accepted every cycle while the front stage is empty or the
// two-entry queue has room; the first result of a request passes through the
// front stage register, the queue, the back working registers and the output
// register. Configuration registers are read live and should be written only
// while no request is in flight.
module lcd_chunked_window_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic                              in_transfer_busy,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic [7:0]                        out_spi_byte,
  output logic                              out_is_data,
  output logic [31:0]                       out_transfer_address,
  output logic [21:0]                       out_transfer_bytes,
  output logic                              out_more_pending,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [lcwseq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcwseq_pkg::CFG_DATA_W-1:0] cfg_data
);

  lcwseq_pkg::cfg_t     cfg_r, cfg_nxt;
  logic                 push_valid;
  logic                 push_ready;
  lcwseq_pkg::q_entry_t push_entry;
  logic                 pop_valid;
  logic                 pop_ready;
  lcwseq_pkg::q_entry_t pop_entry;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lcwseq_pkg::REG_RECT_LEFT:    cfg_nxt.left   = cfg_data[9:0];
        lcwseq_pkg::REG_RECT_TOP:     cfg_nxt.top    = cfg_data[9:0];
        lcwseq_pkg::REG_RECT_WIDTH:   cfg_nxt.width  = cfg_data[10:0];
        lcwseq_pkg::REG_RECT_HEIGHT:  cfg_nxt.height = cfg_data[10:0];
        lcwseq_pkg::REG_BAND_ROWS:    cfg_nxt.band   = cfg_data[10:0];
        lcwseq_pkg::REG_PANEL_OFFSET: cfg_nxt.offset = cfg_data[7:0];
        lcwseq_pkg::REG_PIXEL_BASE:   cfg_nxt.base   = cfg_data[31:0];
        default:                      cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left   <= 10'd0;
      cfg_r.top    <= 10'd0;
      cfg_r.width  <= 11'd1;
      cfg_r.height <= 11'd0;
      cfg_r.band   <= 11'd1;
      cfg_r.offset <= 8'd0;
      cfg_r.base   <= 32'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lcwseq_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_transfer_busy (in_transfer_busy),
    .cfg              (cfg_r),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_entry       (push_entry)
  );

  lcwseq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  lcwseq_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .pop_valid            (pop_valid),
    .pop_ready            (pop_ready),
    .pop_entry            (pop_entry),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_spi_byte         (out_spi_byte),
    .out_is_data          (out_is_data),
    .out_transfer_address (out_transfer_address),
    .out_transfer_bytes   (out_transfer_bytes),
    .out_more_pending     (out_more_pending),
    .out_last             (out_last)
  );

endmodule

// ===== rtl/core/lcwseq_front.sv =====
`timescale 1ns / 1ps
// Front part: accepts requests, keeps the armed flag and row count, classifies
// each continue request and forms the queue entry. Uses lcwseq_pkg.
module lcwseq_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic                  in_transfer_busy,
  input  lcwseq_pkg::cfg_t      cfg,
  output logic                  push_valid,
  input  logic                  push_ready,
  output lcwseq_pkg::q_entry_t  push_entry
);

  logic                    armed_r, armed_nxt;
  logic [10:0]             rows_done_r, rows_done_nxt;
  logic                    s1_valid_r, s1_valid_nxt;
  lcwseq_pkg::front_item_t s1_r, s1_nxt;

  logic        accept;
  logic [10:0] remaining;
  logic [10:0] limit;
  logic [10:0] rows;
  logic [10:0] rows_sum;
  logic [15:0] y0;

  assign in_ready = !s1_valid_r || push_ready;
  assign accept   = in_valid && in_ready;

  assign remaining = cfg.height - rows_done_r;
  assign limit     = (cfg.band == 11'd0) ? 11'd1 : cfg.band;
  assign rows      = (remaining < limit) ? remaining : limit;
  assign rows_sum  = rows_done_r + rows;
  assign y0        = 16'(cfg.top) + 16'(rows_done_r) + 16'(cfg.offset);

  always_comb begin
    armed_nxt     = armed_r;
    rows_done_nxt = rows_done_r;
    s1_valid_nxt  = s1_valid_r && !push_ready;
    s1_nxt        = s1_r;
    if (accept) begin
      if (!in_mode) begin
        armed_nxt     = 1'b1;
        rows_done_nxt = 11'd0;
      end else begin
        s1_valid_nxt     = 1'b1;
        s1_nxt.is_band   = 1'b0;
        s1_nxt.more      = 1'b0;
        s1_nxt.x0        = 16'(cfg.left);
        s1_nxt.x1        = 16'(cfg.left) + 16'(cfg.width) - 16'd1;
        s1_nxt.y0        = y0;
        s1_nxt.y1        = y0 + 16'(rows) - 16'd1;
        s1_nxt.rows      = rows;
        s1_nxt.rows_base = rows_done_r;
        if (!armed_r) begin
          s1_nxt.more = 1'b0;
        end else if (in_transfer_busy) begin
          s1_nxt.more = 1'b1;
        end else if (rows_done_r >= cfg.height) begin
          armed_nxt   = 1'b0;
          s1_nxt.more = 1'b0;
        end else begin
          s1_nxt.is_band = 1'b1;
          s1_nxt.more    = (rows_sum < cfg.height);
          rows_done_nxt  = rows_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      rows_done_r <= 11'd0;
      s1_valid_r  <= 1'b0;
    end else begin
      armed_r     <= armed_nxt;
      rows_done_r <= rows_done_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign push_valid           = s1_valid_r;
  assign push_entry.is_band   = s1_r.is_band;
  assign push_entry.more      = s1_r.more;
  assign push_entry.x0        = s1_r.x0;
  assign push_entry.x1        = s1_r.x1;
  assign push_entry.y0        = s1_r.y0;
  assign push_entry.y1        = s1_r.y1;
  assign push_entry.len_prod  = 22'(s1_r.rows) * 22'(cfg.width);
  assign push_entry.addr_prod = 22'(s1_r.rows_base) * 22'(cfg.width);

endmodule

// ===== rtl/core/lcwseq_queue.sv =====
`timescale 1ns / 1ps
// Short queue between the front and back parts of the sequencer.
// Depth and entry type come from lcwseq_pkg.
module lcwseq_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  lcwseq_pkg::q_entry_t  push_entry,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output lcwseq_pkg::q_entry_t  pop_entry
);

  lcwseq_pkg::q_entry_t mem_r [lcwseq_pkg::Q_DEPTH];

  logic [lcwseq_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lcwseq_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lcwseq_pkg::Q_CNT_W-1:0] count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  localparam logic [lcwseq_pkg::Q_PTR_W-1:0] PTR_LAST =
    lcwseq_pkg::Q_PTR_W'(lcwseq_pkg::Q_DEPTH - 1);
  localparam logic [lcwseq_pkg::Q_CNT_W-1:0] CNT_FULL =
    lcwseq_pkg::Q_CNT_W'(lcwseq_pkg::Q_DEPTH);

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/lcwseq_back.sv =====
`timescale 1ns / 1ps
// Back part: takes queue entries and plays out a status result, or the window
// bytes and the transfer descriptor, one result per cycle through an output
// register while out_ready does not stall it. Uses lcwseq_pkg.
module lcwseq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcwseq_pkg::cfg_t      cfg,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  lcwseq_pkg::q_entry_t  pop_entry,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_spi_byte,
  output logic                  out_is_data,
  output logic [31:0]           out_transfer_address,
  output logic [21:0]           out_transfer_bytes,
  output logic                  out_more_pending,
  output logic                  out_last
);

  localparam logic [3:0] STEP_CASET = 4'd0;
  localparam logic [3:0] STEP_X0_HI = 4'd1;
  localparam logic [3:0] STEP_X0_LO = 4'd2;
  localparam logic [3:0] STEP_X1_HI = 4'd3;
  localparam logic [3:0] STEP_X1_LO = 4'd4;
  localparam logic [3:0] STEP_RASET = 4'd5;
  localparam logic [3:0] STEP_Y0_HI = 4'd6;
  localparam logic [3:0] STEP_Y0_LO = 4'd7;
  localparam logic [3:0] STEP_Y1_HI = 4'd8;
  localparam logic [3:0] STEP_Y1_LO = 4'd9;
  localparam logic [3:0] STEP_RAMWR = 4'd10;
  localparam logic [3:0] STEP_DESC  = 4'd11;

  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  lcwseq_pkg::back_state_t state_r, state_nxt;

  logic [3:0]  step_r, step_nxt;
  logic        is_band_r, is_band_nxt;
  logic        more_r, more_nxt;
  logic [15:0] x0_r, x0_nxt, x1_r, x1_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [21:0] len_r, len_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_dc_r, out_dc_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;
  logic [21:0] out_len_r, out_len_nxt;
  logic        out_more_r, out_more_nxt;
  logic        out_last_r, out_last_nxt;

  logic adv;
  logic last_step;
  logic do_pop;

  logic [1:0]  res_kind;
  logic [7:0]  res_byte;
  logic        res_dc;
  logic [31:0] res_addr;
  logic [21:0] res_len;
  logic        res_more;
  logic        res_last;

  assign last_step = !is_band_r || (step_r == STEP_DESC);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcwseq_pkg::BACK_IDLE: begin
        if (pop_valid) begin
          state_nxt = lcwseq_pkg::BACK_RUN;
        end
      end
      lcwseq_pkg::BACK_RUN: begin
        if (adv && last_step && !pop_valid) begin
          state_nxt = lcwseq_pkg::BACK_IDLE;
        end
      end
      default: state_nxt = lcwseq_pkg::BACK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    adv       = 1'b0;
    pop_ready = 1'b0;
    case (state_r)
      lcwseq_pkg::BACK_IDLE: begin
        pop_ready = 1'b1;
      end
      lcwseq_pkg::BACK_RUN: begin
        adv       = !out_valid_r || out_ready;
        pop_ready = adv && last_step;
      end
      default: begin
        adv       = 1'b0;
        pop_ready = 1'b0;
      end
    endcase
  end

  assign do_pop = pop_valid && pop_ready;

  // result of the current step
  always_comb begin
    res_kind = lcwseq_pkg::KIND_BYTE;
    res_byte = 8'd0;
    res_dc   = 1'b1;
    res_addr = 32'd0;
    res_len  = 22'd0;
    res_more = 1'b0;
    res_last = 1'b0;
    if (!is_band_r) begin
      res_kind = lcwseq_pkg::KIND_STATUS;
      res_dc   = 1'b0;
      res_more = more_r;
      res_last = 1'b1;
    end else begin
      case (step_r)
        STEP_CASET: begin
          res_byte = CMD_CASET;
          res_dc   = 1'b0;
        end
        STEP_X0_HI: res_byte = x0_r[15:8];
        STEP_X0_LO: res_byte = x0_r[7:0];
        STEP_X1_HI: res_byte = x1_r[15:8];
        STEP_X1_LO: res_byte = x1_r[7:0];
        STEP_RASET: begin
          res_byte = CMD_RASET;
          res_dc   = 1'b0;
        end
        STEP_Y0_HI: res_byte = y0_r[15:8];
        STEP_Y0_LO: res_byte = y0_r[7:0];
        STEP_Y1_HI: res_byte = y1_r[15:8];
        STEP_Y1_LO: res_byte = y1_r[7:0];
        STEP_RAMWR: begin
          res_byte = CMD_RAMWR;
          res_dc   = 1'b0;
        end
        STEP_DESC: begin
          res_kind = lcwseq_pkg::KIND_DESC;
          res_addr = addr_r;
          res_len  = len_r;
          res_more = more_r;
          res_last = 1'b1;
        end
        default: begin
          res_byte = 8'd0;
        end
      endcase
    end
  end

  // working registers and output register
  always_comb begin
    step_nxt    = step_r;
    is_band_nxt = is_band_r;
    more_nxt    = more_r;
    x0_nxt      = x0_r;
    x1_nxt      = x1_r;
    y0_nxt      = y0_r;
    y1_nxt      = y1_r;
    addr_nxt    = addr_r;
    len_nxt     = len_r;
    if (do_pop) begin
      step_nxt    = STEP_CASET;
      is_band_nxt = pop_entry.is_band;
      more_nxt    = pop_entry.more;
      x0_nxt      = pop_entry.x0;
      x1_nxt      = pop_entry.x1;
      y0_nxt      = pop_entry.y0;
      y1_nxt      = pop_entry.y1;
      addr_nxt    = cfg.base + 32'({pop_entry.addr_prod, 1'b0});
      len_nxt     = pop_entry.len_prod[21] ? lcwseq_pkg::BYTES_MAX
                                           : {pop_entry.len_prod[20:0], 1'b0};
    end else if (adv) begin
      step_nxt = step_r + 4'd1;
    end

    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_dc_nxt    = out_dc_r;
    out_addr_nxt  = out_addr_r;
    out_len_nxt   = out_len_r;
    out_more_nxt  = out_more_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = res_kind;
      out_byte_nxt  = res_byte;
      out_dc_nxt    = res_dc;
      out_addr_nxt  = res_addr;
      out_len_nxt   = res_len;
      out_more_nxt  = res_more;
      out_last_nxt  = res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcwseq_pkg::BACK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    is_band_r  <= is_band_nxt;
    more_r     <= more_nxt;
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    y0_r       <= y0_nxt;
    y1_r       <= y1_nxt;
    addr_r     <= addr_nxt;
    len_r      <= len_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_dc_r   <= out_dc_nxt;
    out_addr_r <= out_addr_nxt;
    out_len_r  <= out_len_nxt;
    out_more_r <= out_more_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_spi_byte         = out_byte_r;
  assign out_is_data          = out_dc_r;
  assign out_transfer_address = out_addr_r;
  assign out_transfer_bytes   = out_len_r;
  assign out_more_pending     = out_more_r;
  assign out_last             = out_last_r;

endmodule

// ===== rtl/core/lcwseq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the banded display window sequencer, bound to the top.
// Depends on lcwseq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcwseq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_mode,
  input logic                              in_transfer_busy,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        out_kind,
  input logic [7:0]                        out_spi_byte,
  input logic                              out_is_data,
  input logic [31:0]                       out_transfer_address,
  input logic [21:0]                       out_transfer_bytes,
  input logic                              out_more_pending,
  input logic                              out_last
);

  `LCW_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_mode) && $stable(in_transfer_busy))
  `LCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_spi_byte) && $stable(out_transfer_address) && $stable(out_last))
  `LCW_ASSERT_IMP(a_byte_fields, out_valid && out_kind == lcwseq_pkg::KIND_BYTE, !out_last && !out_more_pending && out_transfer_bytes == 22'd0)
  `LCW_ASSERT_IMP(a_desc_fields, out_valid && out_kind == lcwseq_pkg::KIND_DESC, out_last && out_is_data && out_spi_byte == 8'd0)
  `LCW_ASSERT_IMP(a_status_fields, out_valid && out_kind == lcwseq_pkg::KIND_STATUS, out_last && !out_is_data && out_transfer_bytes == 22'd0)

endmodule

bind lcd_chunked_window_sequencer lcwseq_checker u_lcwseq_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .in_mode              (in_mode),
  .in_transfer_busy     (in_transfer_busy),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_kind             (out_kind),
  .out_spi_byte         (out_spi_byte),
  .out_is_data          (out_is_data),
  .out_transfer_address (out_transfer_address),
  .out_transfer_bytes   (out_transfer_bytes),
  .out_more_pending     (out_more_pending),
  .out_last             (out_last)
);

// ===== bench/lcd_chunked_window_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lcd_chunked_window_sequencer: directed table plus random
// start/continue sequences, checked against a band planner kept in step with the block.
// Depends on lcwseq_pkg and the RTL of the block only.
module lcd_chunked_window_sequencer_tb;
  import lcwseq_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int SETTLE_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 18;
  localparam int DIRECTED_ROWS = 41;

  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_CONTINUE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  spi_byte;
    logic        is_data;
    logic [31:0] address;
    logic [21:0] length;
    logic        more;
    logic        last;
  } window_result_t;

  typedef enum logic {
    STEP_WRITE,
    STEP_REQUEST
  } step_kind_t;

  typedef struct packed {
    step_kind_t             kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  value;
    logic                   mode;
    logic                   busy;
    logic                   typed;
    logic                   more;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic in_transfer_busy = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_spi_byte;
  logic out_is_data;
  logic [31:0] out_transfer_address;
  logic [21:0] out_transfer_bytes;
  logic out_more_pending;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t window_cfg;
  logic sequence_armed;
  logic [10:0] band_row_count;
  window_result_t planned[12];
  window_result_t window_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;

  step_t directed_steps[DIRECTED_ROWS] = '{
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b0, 1'b1, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_START,    1'b1, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b1, 1'b1, 1'b1},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b0, 1'b1, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b0, 1'b1, 1'b0},
    '{STEP_WRITE, REG_RECT_LEFT,    32'd1023, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_RECT_TOP,     32'd1023, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_RECT_WIDTH,   32'd1024, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_RECT_HEIGHT,  32'd5,    1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_BAND_ROWS,    32'd0,    1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_PANEL_OFFSET, 32'd255,  1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_PIXEL_BASE,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_START,    1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b1, 1'b1, 1'b1},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_RECT_HEIGHT,  32'd1,    1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b0, 1'b1, 1'b0},
    '{STEP_WRITE, REG_RECT_LEFT,    32'd0,    1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_RECT_TOP,     32'd0,    1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_PANEL_OFFSET, 32'd0,    1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_RECT_WIDTH,   32'd0,    1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_RECT_HEIGHT,  32'd2047, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_BAND_ROWS,    32'd2047, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_PIXEL_BASE,   32'd0,    1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_START,    1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_RECT_WIDTH,   32'd2047, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_START,    1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b0, 1'b1, 1'b0},
    '{STEP_WRITE, REG_RECT_WIDTH,   32'd1,    1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_RECT_HEIGHT,  32'd7,    1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_BAND_ROWS,    32'd3,    1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_PIXEL_BASE,   32'h1234_5678, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_WRITE, REG_UNUSED,       32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_START,    1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b0, 1'b0, 1'b0},
    '{STEP_REQUEST, 3'd0, 32'd0, MODE_CONTINUE, 1'b0, 1'b1, 1'b0}
  };

  lcd_chunked_window_sequencer DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_transfer_busy     (in_transfer_busy),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_spi_byte         (out_spi_byte),
    .out_is_data          (out_is_data),
    .out_transfer_address (out_transfer_address),
    .out_transfer_bytes   (out_transfer_bytes),
    .out_more_pending     (out_more_pending),
    .out_last             (out_last),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic window_result_t status_result(input logic more);
    window_result_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.more = more;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic window_result_t spi_result(input logic [7:0] value, input logic dc);
    window_result_t r;
    r = '0;
    r.kind = KIND_BYTE;
    r.spi_byte = value;
    r.is_data = dc;
    return r;
  endfunction

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_RECT_LEFT:    window_cfg.left = value[9:0];
      REG_RECT_TOP:     window_cfg.top = value[9:0];
      REG_RECT_WIDTH:   window_cfg.width = value[10:0];
      REG_RECT_HEIGHT:  window_cfg.height = value[10:0];
      REG_BAND_ROWS:    window_cfg.band = value[10:0];
      REG_PANEL_OFFSET: window_cfg.offset = value[7:0];
      REG_PIXEL_BASE:   window_cfg.base = value;
      default: ;
    endcase
  endtask

  // Work out the results of one request and advance the band state.
  task automatic plan_request(input logic mode, input logic busy, output int count);
    logic [10:0] remaining, band_limit, rows;
    logic [15:0] x0, x1, y0, y1;
    logic [63:0] nbytes;
    window_result_t desc;
    count = 0;
    if (mode == MODE_START) begin
      sequence_armed = 1'b1;
      band_row_count = '0;
    end else if (!sequence_armed) begin
      planned[0] = status_result(1'b0);
      count = 1;
    end else if (busy) begin
      planned[0] = status_result(1'b1);
      count = 1;
    end else if (band_row_count >= window_cfg.height) begin
      sequence_armed = 1'b0;
      planned[0] = status_result(1'b0);
      count = 1;
    end else begin
      remaining = window_cfg.height - band_row_count;
      band_limit = (window_cfg.band == '0) ? 11'd1 : window_cfg.band;
      rows = (remaining < band_limit) ? remaining : band_limit;
      x0 = 16'(window_cfg.left);
      x1 = 16'(window_cfg.left) + 16'(window_cfg.width) - 16'd1;
      y0 = 16'(window_cfg.top) + 16'(band_row_count) + 16'(window_cfg.offset);
      y1 = y0 + 16'(rows) - 16'd1;
      nbytes = 64'(rows) * 64'(window_cfg.width) * 64'd2;
      desc = '0;
      desc.kind = KIND_DESC;
      desc.is_data = 1'b1;
      desc.address = window_cfg.base + 32'(band_row_count) * 32'(window_cfg.width) * 32'd2;
      desc.length = (nbytes > 64'(BYTES_MAX)) ? BYTES_MAX : nbytes[21:0];
      desc.last = 1'b1;
      planned[0] = spi_result(CMD_CASET, 1'b0);
      planned[1] = spi_result(x0[15:8], 1'b1);
      planned[2] = spi_result(x0[7:0], 1'b1);
      planned[3] = spi_result(x1[15:8], 1'b1);
      planned[4] = spi_result(x1[7:0], 1'b1);
      planned[5] = spi_result(CMD_RASET, 1'b0);
      planned[6] = spi_result(y0[15:8], 1'b1);
      planned[7] = spi_result(y0[7:0], 1'b1);
      planned[8] = spi_result(y1[15:8], 1'b1);
      planned[9] = spi_result(y1[7:0], 1'b1);
      planned[10] = spi_result(CMD_RAMWR, 1'b0);
      band_row_count = band_row_count + rows;
      desc.more = band_row_count < window_cfg.height;
      planned[11] = desc;
      count = 12;
    end
  endtask

  task automatic send_request(input logic mode, input logic busy,
                              input logic typed, input logic typed_more);
    int gap, count;
    gap = tx_fast ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_transfer_busy <= busy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    plan_request(mode, busy, count);
    if (typed) begin
      window_results.push_back(status_result(typed_more));
    end else begin
      for (int i = 0; i < count; i++) window_results.push_back(planned[i]);
    end
  endtask

  // Hold off the sender until every pending result is back and the block is quiet.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (window_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    apply_register(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
    if (expected !== actual) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, expected, actual);
    end
  endtask

  initial begin
    int stall;
    window_result_t exp_result;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = rx_fast ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (window_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual kind %0d byte 0x%0h",
                 $time, out_kind, out_spi_byte);
      end else begin
        exp_result = window_results.pop_front();
        compare_field("kind", 32'(exp_result.kind), 32'(out_kind));
        compare_field("spi_byte", 32'(exp_result.spi_byte), 32'(out_spi_byte));
        compare_field("is_data", 32'(exp_result.is_data), 32'(out_is_data));
        compare_field("transfer_address", exp_result.address, out_transfer_address);
        compare_field("transfer_bytes", 32'(exp_result.length), 32'(out_transfer_bytes));
        compare_field("more_pending", 32'(exp_result.more), 32'(out_more_pending));
        compare_field("last", 32'(exp_result.last), 32'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results pending", $time, window_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] value;
    bit prev_request;
    int sel, issued, bands;
    window_cfg = '0;
    window_cfg.width = 11'd1;
    window_cfg.band = 11'd1;
    sequence_armed = 1'b0;
    band_row_count = '0;
    prev_request = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_steps[i].kind == STEP_WRITE) begin
        if (prev_request) settle_block();
        write_reg(directed_steps[i].reg_idx, directed_steps[i].value);
        prev_request = 1'b0;
      end else begin
        send_request(directed_steps[i].mode, directed_steps[i].busy,
                     directed_steps[i].typed, directed_steps[i].more);
        prev_request = 1'b1;
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_block();
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      for (int idx = 0; idx < 8; idx++) begin
        if (phase == 0 || $urandom_range(0, 9) < 5) begin
          sel = $urandom_range(0, 9);
          case (idx)
            REG_RECT_LEFT, REG_RECT_TOP:
              value = (sel < 3) ? 32'd0 : (sel < 5) ? 32'd1023 :
                      (sel < 8) ? $urandom_range(0, 40) : $urandom;
            REG_RECT_WIDTH:
              value = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd1024 : (sel == 2) ? 32'd2047 :
                      (sel < 8) ? $urandom_range(1, 64) : $urandom;
            REG_RECT_HEIGHT:
              value = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd1024 :
                      (sel < 9) ? $urandom_range(1, 40) : $urandom;
            REG_BAND_ROWS:
              value = (sel == 0) ? 32'd0 : (sel == 1) ? 32'd1024 :
                      (sel < 8) ? $urandom_range(1, 12) : $urandom;
            REG_PANEL_OFFSET:
              value = (sel < 3) ? 32'd0 : (sel < 5) ? 32'd255 : $urandom;
            default:
              value = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
          endcase
          write_reg(CFG_IDX_W'(idx), value);
        end
      end
      issued = 0;
      while (issued < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 29) == 0) settle_block();
        if ($urandom_range(0, 6) != 0) begin
          send_request(MODE_START, 1'($urandom), 1'b0, 1'b0);
          issued++;
          bands = $urandom_range(1, 8);
          for (int k = 0; k < bands; k++) begin
            send_request(MODE_CONTINUE, ($urandom_range(0, 6) == 0), 1'b0, 1'b0);
            issued++;
          end
        end else begin
          send_request(1'($urandom), 1'($urandom), 1'b0, 1'b0);
          issued++;
        end
      end
    end

    settle_block();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
